[hw/rtl/sspc_pkg.sv]
`default_nettype none
package sspc_pkg;
   localparam int ACCEL_TICKS_DEF    = 10000;
   localparam int START_INTERVAL_DEF = 30;
   localparam int AUTO_PERIOD_DEF    = 100;

   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_AUTO   = 2'd1;
   localparam logic [1:0] MODE_NONE   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_DIV,
      ST_CMD_FIN,
      ST_AIM,
      ST_TICK,
      ST_AUTO_MOD,
      ST_AUTO_FIN,
      ST_MAN_TAIL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DV_TARGET,
      DV_LOW,
      DV_HIGH,
      DV_PERIOD
   } div_job_type;
endpackage
`default_nettype wire

[hw/rtl/stepper_sweep_position_controller.sv]
// result path: a plain tick or a rejected command goes through ST_TICK or ST_CMD to
//    ST_OUT; a sweep tick adds a remainder pass in ST_AUTO_MOD, a manual tick that
//    re-aims and every accepted command run the shared 32-bit restoring divider
//    (one quotient bit a cycle), up to three times per command
// throughput: one request at a time, the next is taken once the result is taken
// reset: synchronous, active high; request and divider registers are not reset
`default_nettype none
module stepper_sweep_position_controller
   import sspc_pkg::*;
#(
   parameter int ACCEL_TICKS    = ACCEL_TICKS_DEF,
   parameter int START_INTERVAL = START_INTERVAL_DEF,
   parameter int AUTO_PERIOD    = AUTO_PERIOD_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic               req_home_sensor,
   input  wire logic               req_cmd_auto,
   input  wire logic [2:0]         req_cmd_microstep,
   input  wire logic [11:0]        req_cmd_angle,
   input  wire logic [11:0]        req_cmd_start_angle,
   input  wire logic [11:0]        req_cmd_end_angle,
   input  wire logic [15:0]        req_cmd_speed,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_step_toggle,
   output logic                    rsp_direction,
   output logic signed [13:0]      rsp_position,
   output logic                    rsp_timer_enable,
   output logic [15:0]             rsp_tick_period,
   output logic                    rsp_done_res,
   output logic                    rsp_homed
);
   localparam logic [13:0] ACC_LIM = 14'(ACCEL_TICKS);
   localparam logic [15:0] START_I = 16'(START_INTERVAL);
   localparam logic [15:0] AUTO_P  = 16'(AUTO_PERIOD);

   state_type state_ff, state_in;

   logic signed [13:0] pos_ff, pos_in, tgt_ff, tgt_in;
   logic [12:0] low_ff, low_in, high_ff, high_in, full_ff, full_in;
   logic [2:0]  ms_now_ff, ms_now_in, ms_prev_ff, ms_prev_in;
   logic homed_ff, homed_in, done_ff, done_in, rdy_ff, rdy_in, dir_ff, dir_in;
   logic resch_ff, resch_in, ton_ff, ton_in, tog_ff, tog_in;
   logic [1:0]  mode_ff, mode_in;
   logic [13:0] acc_ff, acc_in;
   logic [15:0] itv_ff, itv_in, mper_ff, mper_in, tper_ff, tper_in;
   logic [14:0] dec_ff, dec_in;
   logic [11:0] pang_ff, pang_in;

   // captured request
   logic        kind_ff, kind_in, sens_ff, sens_in, cauto_ff, cauto_in;
   logic [2:0]  code_ff, code_in;
   logic [11:0] sa_ff, sa_in, ea_ff, ea_in;
   logic [15:0] spd_ff, spd_in;

   // shared divider
   div_job_type job_ff, job_in;
   logic [31:0] num_ff, num_in, den_ff, den_in, quo_ff, quo_in, rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [11:0] aimang_ff, aimang_in;
   logic [32:0] trial;

   assign trial = {rem_ff, num_ff[31]} - {1'b0, den_ff};

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_step_toggle  = tog_ff;
   assign rsp_direction    = dir_ff;
   assign rsp_position     = pos_ff;
   assign rsp_timer_enable = ton_ff;
   assign rsp_tick_period  = tper_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_homed        = homed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0; tgt_ff <= '0; low_ff <= '0; high_ff <= '0; full_ff <= '0;
         ms_now_ff <= '0; ms_prev_ff <= '0; homed_ff <= 1'b0; done_ff <= 1'b0;
         mode_ff <= MODE_NONE; rdy_ff <= 1'b1; acc_ff <= '0; itv_ff <= START_I;
         dec_ff <= 15'd4; dir_ff <= 1'b0; pang_ff <= '0; resch_ff <= 1'b0;
         mper_ff <= 16'd2000; ton_ff <= 1'b1; tper_ff <= AUTO_P; tog_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in; tgt_ff <= tgt_in; low_ff <= low_in; high_ff <= high_in;
         full_ff <= full_in; ms_now_ff <= ms_now_in; ms_prev_ff <= ms_prev_in;
         homed_ff <= homed_in; done_ff <= done_in; mode_ff <= mode_in;
         rdy_ff <= rdy_in; acc_ff <= acc_in; itv_ff <= itv_in; dec_ff <= dec_in;
         dir_ff <= dir_in; pang_ff <= pang_in; resch_ff <= resch_in;
         mper_ff <= mper_in; ton_ff <= ton_in; tper_ff <= tper_in; tog_ff <= tog_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; sens_ff <= sens_in; cauto_ff <= cauto_in;
      code_ff <= code_in; sa_ff <= sa_in; ea_ff <= ea_in; spd_ff <= spd_in;
      job_ff <= job_in; num_ff <= num_in; den_ff <= den_in; quo_ff <= quo_in;
      rem_ff <= rem_in; cnt_ff <= cnt_in; aimang_ff <= aimang_in;
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff; tgt_in = tgt_ff; low_in = low_ff; high_in = high_ff;
      full_in = full_ff; ms_now_in = ms_now_ff; ms_prev_in = ms_prev_ff;
      homed_in = homed_ff; done_in = done_ff; mode_in = mode_ff; rdy_in = rdy_ff;
      acc_in = acc_ff; itv_in = itv_ff; dec_in = dec_ff; dir_in = dir_ff;
      pang_in = pang_ff; resch_in = resch_ff; mper_in = mper_ff; ton_in = ton_ff;
      tper_in = tper_ff; tog_in = tog_ff;
      kind_in = kind_ff; sens_in = sens_ff; cauto_in = cauto_ff; code_in = code_ff;
      sa_in = sa_ff; ea_in = ea_ff; spd_in = spd_ff;
      job_in = job_ff; num_in = num_ff; den_in = den_ff; quo_in = quo_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; aimang_in = aimang_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind; sens_in = req_home_sensor; cauto_in = req_cmd_auto;
               code_in = req_cmd_microstep; sa_in = req_cmd_start_angle;
               ea_in = req_cmd_end_angle; spd_in = req_cmd_speed;
               tog_in = 1'b0;
               aimang_in = req_cmd_angle;
               state_in = req_kind ? ST_CMD : ST_TICK;
            end
         end
         ST_CMD: begin
            if (!(homed_ff && done_ff)) begin
               state_in = ST_OUT;
            end else begin
               mode_in = {1'b0, cauto_ff};
               if (code_ff != ms_prev_ff) begin
                  homed_in = 1'b0; resch_in = 1'b1;
               end
               ms_now_in = code_ff;
               full_in = (code_ff <= 3'd4) ? 13'(13'd400 << code_ff) : 13'd0;
               pang_in = aimang_ff;
               if (cauto_ff) begin
                  dec_in = spd_ff[15:1]; rdy_in = 1'b0; resch_in = 1'b1;
                  homed_in = 1'b0; aimang_in = sa_ff;
                  job_in = DV_LOW;
                  num_in = 32'(sa_ff) * 32'(full_in);
                  den_in = 32'd3600;
               end else if (spd_ff == 16'd0 || code_ff > 3'd4) begin
                  mper_in = 16'hFFFF;
                  job_in = DV_TARGET;
                  num_in = 32'(2 * 32'(aimang_ff) * 32'(full_in) + 32'd3600);
                  den_in = 32'd7200;
               end else begin
                  job_in = DV_PERIOD;
                  num_in = 32'd150000;
                  den_in = 32'(32'(spd_ff) << (code_ff + 3'd1));
               end
               rem_in = '0; quo_in = '0; cnt_in = 6'd32;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], num_ff[31]}; quo_in = {quo_ff[30:0], 1'b0};
            end
            num_in = {num_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = ST_CMD_FIN;
         end
         ST_CMD_FIN: begin
            rem_in = '0; quo_in = '0; cnt_in = 6'd32;
            state_in = ST_DIV;
            case (job_ff)
               DV_PERIOD: begin
                  mper_in = (quo_ff > 32'd65535) ? 16'hFFFF : quo_ff[15:0];
                  job_in = DV_TARGET;
                  num_in = 32'(2 * 32'(aimang_ff) * 32'(full_ff) + 32'd3600);
                  den_in = 32'd7200;
               end
               DV_LOW: begin
                  low_in = quo_ff[12:0];
                  job_in = DV_HIGH;
                  num_in = 32'(ea_ff) * 32'(full_ff);
                  den_in = 32'd3600;
               end
               DV_HIGH: begin
                  high_in = quo_ff[12:0];
                  job_in = DV_TARGET;
                  num_in = 32'(2 * 32'(aimang_ff) * 32'(full_ff) + 32'd3600);
                  den_in = 32'd7200;
               end
               DV_TARGET: begin
                  tgt_in = quo_ff[13:0];
                  state_in = ST_AIM;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_AIM: begin
            if (tgt_ff > pos_ff) begin
               dir_in = 1'b0; ton_in = 1'b1; tper_in = mper_ff;
            end else if (tgt_ff < pos_ff) begin
               dir_in = 1'b1; ton_in = 1'b1; tper_in = mper_ff;
            end else if (mode_ff == MODE_MANUAL) begin
               ton_in = 1'b0;
            end
            if (kind_ff) state_in = ST_OUT;
            else begin
               resch_in = 1'b0;
               state_in = ST_MAN_TAIL;
            end
         end
         ST_TICK: begin
            tog_in = (mode_ff == MODE_MANUAL) || !homed_ff;
            state_in = ST_OUT;
            if (!homed_ff) begin
               dir_in = 1'b1; done_in = 1'b0;
               if (sens_ff) begin
                  homed_in = 1'b1; ms_prev_in = ms_now_ff;
                  pos_in = 14'(full_ff[12:1]); done_in = 1'b1;
                  if (tgt_ff > 14'(full_ff[12:1])) dir_in = 1'b0;
                  else if (tgt_ff < 14'(full_ff[12:1])) dir_in = 1'b1;
               end
            end
            if (homed_in) begin
               if (mode_ff == MODE_AUTO) begin
                  resch_in = 1'b0;
                  if (rdy_ff) begin
                     acc_in = acc_ff + 14'd1;
                     itv_in = itv_ff;
                     if (acc_in >= ACC_LIM) begin
                        itv_in = (itv_ff > 16'(dec_ff)) ? itv_ff - 16'(dec_ff) : 16'd1;
                        acc_in = '0;
                     end
                     if (itv_in == 16'd0) itv_in = 16'd1;
                     num_in = 32'(acc_in); den_in = 32'(itv_in);
                     rem_in = '0; quo_in = '0; cnt_in = 6'd14;
                     num_in = {acc_in, 18'd0};
                     state_in = ST_AUTO_MOD;
                  end else begin
                     tog_in = !tog_in;
                     if (pos_in == tgt_ff) begin
                        rdy_in = 1'b1; tper_in = AUTO_P;
                     end else begin
                        pos_in = dir_in ? pos_in - 14'sd1 : pos_in + 14'sd1;
                     end
                  end
               end else if (mode_ff == MODE_MANUAL) begin
                  if (resch_ff) begin
                     pos_in = pos_in; aimang_in = pang_ff;
                     job_in = DV_TARGET;
                     num_in = 32'(2 * 32'(pang_ff) * 32'(full_ff) + 32'd3600);
                     den_in = 32'd7200;
                     rem_in = '0; quo_in = '0; cnt_in = 6'd32;
                     state_in = ST_DIV;
                  end else begin
                     if (pos_in == tgt_ff) begin
                        done_in = 1'b1; ton_in = 1'b0;
                     end else begin
                        done_in = 1'b0;
                        pos_in = dir_in ? pos_in - 14'sd1 : pos_in + 14'sd1;
                     end
                  end
               end
            end
         end
         ST_MAN_TAIL: begin
            if (pos_ff == tgt_ff) begin
               done_in = 1'b1; ton_in = 1'b0;
            end else begin
               done_in = 1'b0;
               pos_in = dir_ff ? pos_ff - 14'sd1 : pos_ff + 14'sd1;
            end
            state_in = ST_OUT;
         end
         ST_AUTO_MOD: begin
            if (!trial[32]) rem_in = trial[31:0];
            else rem_in = {rem_ff[30:0], num_ff[31]};
            num_in = {num_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = ST_AUTO_FIN;
         end
         ST_AUTO_FIN: begin
            if (rem_ff == 32'd0) begin
               if (pos_ff >= $signed({1'b0, high_ff}) ||
                   pos_ff <= $signed({1'b0, low_ff})) begin
                  acc_in = '0; itv_in = START_I; dir_in = !dir_ff;
               end
               tog_in = !tog_ff;
               pos_in = dir_in ? pos_ff - 14'sd1 : pos_ff + 14'sd1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire
